// ----- src/swq_pkg.sv -----
// shared types and constants for the sleep / wake-up queue
// no dependencies
package swq_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_WOKEN  = 2'd2
    } kind_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam int OUT_ID_BITS = 8;

    // controller to datapath
    typedef struct packed {
        logic  latch;
        logic  insert;
        logic  pop;
        logic  load_out;
        kind_t kind;
        logic  last;
    } swq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic action;
        logic full;
        logic head_due;
        logic next_last;
        logic out_free;
    } swq_status_t;

endpackage

// ----- src/swq_if.sv -----
// request and result channel interfaces of the sleep / wake-up queue
// depends on swq_pkg for the result id width
interface swq_req_if
    import swq_pkg::*;
#(
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [ID_BITS-1:0]   thread_id;
    logic [TIME_BITS-1:0] tick_value;

    modport source (output valid, action, thread_id, tick_value, input ready);
    modport sink   (input valid, action, thread_id, tick_value, output ready);
endinterface

interface swq_rsp_if
    import swq_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [OUT_ID_BITS-1:0] woken_id;
    logic                   last;

    modport source (output valid, kind, woken_id, last, input ready);
    modport sink   (input valid, kind, woken_id, last, output ready);
endinterface

// ----- src/swq_ctrl.sv -----
// controller state machine of the sleep / wake-up queue
// depends on swq_pkg
module swq_ctrl
    import swq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  swq_status_t status,
    output swq_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!status.action)
                begin
                    if (status.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (!status.head_due)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free && status.next_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.latch    = 1'b0;
        cmd.insert   = 1'b0;
        cmd.pop      = 1'b0;
        cmd.load_out = 1'b0;
        cmd.kind     = KIND_ACCEPT;
        cmd.last     = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            ST_RUN:
            begin
                if (!status.action)
                begin
                    cmd.load_out = status.out_free;
                    cmd.insert   = status.out_free && !status.full;
                    cmd.kind     = status.full ? KIND_REJECT : KIND_ACCEPT;
                end
                else
                begin
                    cmd.load_out = status.head_due && status.out_free;
                    cmd.pop      = status.head_due && status.out_free;
                    cmd.kind     = KIND_WOKEN;
                    cmd.last     = status.next_last;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/swq_datapath.sv -----
// sorted cell row, request holding registers and result register
// depends on swq_pkg
module swq_datapath
    import swq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_action,
    input  logic [ID_BITS-1:0]     in_thread_id,
    input  logic [TIME_BITS-1:0]   in_tick_value,
    input  swq_cmd_t               cmd,
    output swq_status_t            status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             out_kind,
    output logic [OUT_ID_BITS-1:0] out_woken_id,
    output logic                   out_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [TIME_BITS-1:0] time_reg [DEPTH];
    logic [ID_BITS-1:0]   id_reg   [DEPTH];
    logic [CNT_W-1:0]     count_reg;

    logic                 action_reg;
    logic [ID_BITS-1:0]   hold_id_reg;
    logic [TIME_BITS-1:0] hold_time_reg;

    logic                   out_valid_reg;
    kind_t                  out_kind_reg;
    logic [OUT_ID_BITS-1:0] out_id_reg;
    logic                   out_last_reg;

    logic [DEPTH-1:0] le;
    logic             next_due;
    logic [ID_BITS-1:0] sel_id;

    // entries at or before the held time, valid entries only
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            le[i] = (CNT_W'(i) < count_reg) && (time_reg[i] <= hold_time_reg);
        end
    end

    generate
        if (DEPTH > 1)
        begin : g_next
            assign next_due = (count_reg > CNT_W'(1)) && (time_reg[1] <= hold_time_reg);
        end
        else
        begin : g_single
            assign next_due = 1'b0;
        end
    endgenerate

    assign status.action    = action_reg;
    assign status.full      = (count_reg == CNT_W'(DEPTH));
    assign status.head_due  = le[0];
    assign status.next_last = !next_due;
    assign status.out_free  = !out_valid_reg || out_ready;

    // cell row: each cell keeps, takes the new entry, or shifts
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cmd.insert)
            begin
                if (!le[i])
                begin
                    if (i == 0)
                    begin
                        time_reg[i] <= hold_time_reg;
                        id_reg[i]   <= hold_id_reg;
                    end
                    else if (le[(i > 0) ? i - 1 : 0])
                    begin
                        time_reg[i] <= hold_time_reg;
                        id_reg[i]   <= hold_id_reg;
                    end
                    else
                    begin
                        time_reg[i] <= time_reg[(i > 0) ? i - 1 : 0];
                        id_reg[i]   <= id_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
            else if (cmd.pop && (i < DEPTH - 1))
            begin
                time_reg[i] <= time_reg[(i < DEPTH - 1) ? i + 1 : i];
                id_reg[i]   <= id_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.insert)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    // held request
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg    <= in_action;
            hold_id_reg   <= in_thread_id;
            hold_time_reg <= in_tick_value;
        end
    end

    // result register
    assign sel_id = (cmd.kind == KIND_WOKEN) ? id_reg[0] : hold_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_kind_reg <= cmd.kind;
            out_id_reg   <= OUT_ID_BITS'({{OUT_ID_BITS{1'b0}}, sel_id});
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_woken_id = out_id_reg;
    assign out_last     = out_last_reg;

endmodule

// ----- src/sleep_wakeup_queue_unit.sv -----
// sleep / wake-up queue: a sleep request's result is loaded once the output register is free
// tick request: k due entries give k results, one per cycle off the head of the sorted cell
// row while the output register is free, and none if none is due; the next request is taken
// once all results are loaded, even while a result still waits in the output register
// reset clears the fill count and control state; cell contents are not reset
// depends on swq_pkg, swq_if, swq_ctrl, swq_datapath
module sleep_wakeup_queue_unit
    import swq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    swq_req_if.sink    req,
    swq_rsp_if.source  rsp
);

    // command / status between the controller and the datapath
    swq_cmd_t    cmd;
    swq_status_t status;
    logic        in_ready;

    // controller: idle takes a request, run inserts (or rejects when full) or drains due entries
    swq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign req.ready = in_ready;

    // datapath: sorted cells kept oldest first among equal wake times
    swq_datapath #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_action     (req.action),
        .in_thread_id  (req.thread_id),
        .in_tick_value (req.tick_value),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .out_kind      (rsp.kind),
        .out_woken_id  (rsp.woken_id),
        .out_last      (rsp.last)
    );

endmodule
